### rtl/core/pwt_pkg.sv
// Shared types and constants of the PID controller with twiddle tuning.
package pwt_pkg;

	localparam int ERR_W      = 32;
	localparam int GAIN_W     = 32;
	localparam int REG_W      = 31;
	localparam int DIFF_W     = 33;
	localparam int INTEG_W    = 64;
	localparam int SCALE_BITS = 16;
	localparam int FACTOR_W   = 17;

	localparam logic [FACTOR_W-1:0] SCALE_TENTH = 17'd6554;
	localparam logic [FACTOR_W-1:0] SCALE_UP    = 17'd72090;
	localparam logic [FACTOR_W-1:0] SCALE_DOWN  = 17'd58982;

	localparam logic [REG_W-1:0] TOL_RESET = 31'd655;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		REG_PROP,
		REG_INTEG,
		REG_DERIV,
		REG_TOL
	} cfg_reg_t;

	typedef enum logic [1:0] {
		GAIN_P,
		GAIN_I,
		GAIN_D
	} gain_idx_t;

	typedef enum logic [1:0] {
		PH_INIT,
		PH_RAISED,
		PH_LOWERED
	} tune_phase_t;

	typedef enum logic [2:0] {
		FE_IDLE,
		FE_DECIDE,
		FE_LOAD,
		FE_SCALE,
		FE_WRITE,
		FE_PUSH
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_IDLE,
		BE_MUL,
		BE_ACC,
		BE_SAT
	} be_state_t;

	typedef enum logic [1:0] {
		MS_PROP,
		MS_DERIV,
		MS_INTEG_LO,
		MS_INTEG_HI
	} mul_step_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0]  kp;
		logic signed [GAIN_W-1:0]  ki;
		logic signed [GAIN_W-1:0]  kd;
		logic signed [ERR_W-1:0]   err;
		logic signed [DIFF_W-1:0]  diff;
		logic signed [INTEG_W-1:0] integ;
		logic                      conv;
	} work_t;

endpackage

### rtl/core/pwt_front.sv
// Front end: input buffer, error terms, integral, twiddle tuning and gain reload.
module pwt_front import pwt_pkg::*; #(
	parameter int SUM_BITS = 40
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [ERR_W-1:0] track_error,
	input  logic                    tune_enable,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [REG_W-1:0]        cfg_data,
	output logic                    push_req,
	input  logic                    q_full,
	output work_t                   push_word
);

	localparam int TOTAL_W = REG_W + 2;
	localparam int PROD_W  = REG_W + FACTOR_W;
	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (SCALE_BITS - 1);
	localparam logic signed [GAIN_W-1:0] BEST_RESET = 32'sh7FFF_FFFF;

	function automatic logic signed [GAIN_W-1:0] sat32(input logic signed [GAIN_W+1:0] v);
		if (v > 34'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -34'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[GAIN_W-1:0];
	endfunction

	fe_state_t state_q, state_d;

	logic                    buf_valid_q;
	logic signed [ERR_W-1:0] buf_err_q;
	logic                    buf_tune_q;
	logic                    take, start_load, need_scale, gain_wr;

	logic [REG_W-1:0]         gain_reg_q [3];
	logic [REG_W-1:0]         tol_q;
	logic signed [GAIN_W-1:0] gain_q [3];
	logic [REG_W-1:0]         step_q [3];
	logic signed [ERR_W-1:0]  best_q, last_q;
	logic signed [SUM_BITS-1:0] sum_q;
	tune_phase_t              phase_q;
	gain_idx_t                sel_q, sel_next;
	logic                     load_pend_q, load_run_q;
	gain_idx_t                load_idx_q, load_idx_next, scale_idx_q;

	logic signed [ERR_W-1:0]  item_err_q;
	logic signed [DIFF_W-1:0] item_diff_q;
	logic                     item_tune_q;

	logic [REG_W-1:0]    mul_a_q;
	logic [FACTOR_W-1:0] mul_c_q;
	logic [PROD_W-1:0]   prod_q;

	logic signed [DIFF_W-1:0]   diff_new;
	logic signed [SUM_BITS:0]   sum_wide;
	logic signed [SUM_BITS-1:0] sum_new;
	logic [TOTAL_W-1:0]         step_total;
	logic                       over, hit;
	logic signed [GAIN_W+1:0]   gain_ext, step_ext;
	logic signed [GAIN_W-1:0]   gain_plus, gain_minus;
	logic [PROD_W:0]            rounded;
	logic [PROD_W-SCALE_BITS:0] rounded_sh;
	logic [REG_W-1:0]           scaled;

	assign gain_wr = cfg_we && (cfg_reg_t'(cfg_index) != REG_TOL);

	assign diff_new = DIFF_W'(buf_err_q) - DIFF_W'(last_q);
	assign sum_wide = (SUM_BITS + 1)'(sum_q) + (SUM_BITS + 1)'(buf_err_q);
	assign sum_new  = (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) ?
		{sum_wide[SUM_BITS], {(SUM_BITS - 1){~sum_wide[SUM_BITS]}}} : sum_wide[SUM_BITS-1:0];

	assign step_total = TOTAL_W'(step_q[0]) + TOTAL_W'(step_q[1]) + TOTAL_W'(step_q[2]);
	assign over       = step_total > TOTAL_W'(tol_q);
	assign hit        = item_err_q < best_q;

	assign gain_ext   = (GAIN_W + 2)'(gain_q[sel_q]);
	assign step_ext   = (GAIN_W + 2)'(step_q[sel_q]);
	assign gain_plus  = sat32(gain_ext + step_ext);
	assign gain_minus = sat32(gain_ext - (step_ext <<< 1));

	assign rounded    = (PROD_W + 1)'(prod_q) + ROUND_HALF;
	assign rounded_sh = rounded[PROD_W:SCALE_BITS];
	assign scaled     = (rounded_sh > (PROD_W - SCALE_BITS + 1)'({REG_W{1'b1}})) ?
		{REG_W{1'b1}} : rounded_sh[REG_W-1:0];

	always_comb begin
		case (sel_q)
			GAIN_P:  sel_next = GAIN_I;
			GAIN_I:  sel_next = GAIN_D;
			default: sel_next = GAIN_P;
		endcase
		case (load_idx_q)
			GAIN_P:  load_idx_next = GAIN_I;
			GAIN_I:  load_idx_next = GAIN_D;
			default: load_idx_next = GAIN_P;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		start_load = 1'b0;
		take       = 1'b0;
		push_req   = 1'b0;
		need_scale = item_tune_q && over &&
			((phase_q == PH_RAISED && hit) || phase_q == PH_LOWERED);
		case (state_q)
			FE_IDLE: begin
				if (load_pend_q) begin
					start_load = 1'b1;
					state_d    = FE_LOAD;
				end else if (buf_valid_q) begin
					take    = 1'b1;
					state_d = FE_DECIDE;
				end
			end
			FE_DECIDE: state_d = need_scale ? FE_SCALE : FE_PUSH;
			FE_LOAD:   state_d = FE_SCALE;
			FE_SCALE:  state_d = FE_WRITE;
			FE_WRITE: begin
				if (!load_run_q) begin
					state_d = FE_PUSH;
				end else if (load_idx_q == GAIN_D) begin
					state_d = FE_IDLE;
				end else begin
					state_d = FE_LOAD;
				end
			end
			FE_PUSH: begin
				push_req = 1'b1;
				if (!q_full) begin
					state_d = FE_IDLE;
				end
			end
			default: state_d = FE_IDLE;
		endcase
		in_stall = buf_valid_q && !take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			for (int j = 0; j < 3; j++) begin
				gain_reg_q[j] <= '0;
				gain_q[j]     <= '0;
				step_q[j]     <= '0;
			end
			tol_q       <= TOL_RESET;
			best_q      <= BEST_RESET;
			last_q      <= '0;
			sum_q       <= '0;
			phase_q     <= PH_INIT;
			sel_q       <= GAIN_P;
			load_pend_q <= 1'b0;
			load_run_q  <= 1'b0;
			load_idx_q  <= GAIN_P;
		end else begin
			buf_valid_q <= (in_valid && !in_stall) || (buf_valid_q && !take);

			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PROP, REG_INTEG, REG_DERIV: gain_reg_q[cfg_index] <= cfg_data;
					REG_TOL:                        tol_q <= cfg_data;
					default:                        ;
				endcase
			end
			load_pend_q <= gain_wr || (load_pend_q && !start_load);

			case (state_q)
				FE_IDLE: begin
					if (start_load) begin
						for (int j = 0; j < 3; j++) begin
							gain_q[j] <= {1'b0, gain_reg_q[j]};
						end
						best_q     <= BEST_RESET;
						load_idx_q <= GAIN_P;
						load_run_q <= 1'b1;
					end else if (take) begin
						last_q <= buf_err_q;
						sum_q  <= sum_new;
					end
				end
				FE_DECIDE: begin
					if (item_tune_q) begin
						if (!over) begin
							if (hit) begin
								best_q <= item_err_q;
							end
							phase_q <= PH_INIT;
						end else begin
							case (phase_q)
								PH_INIT: begin
									gain_q[sel_q] <= gain_plus;
									phase_q       <= PH_RAISED;
								end
								PH_RAISED: begin
									if (hit) begin
										best_q  <= item_err_q;
										phase_q <= PH_INIT;
										sel_q   <= sel_next;
									end else begin
										gain_q[sel_q] <= gain_minus;
										phase_q       <= PH_LOWERED;
									end
								end
								PH_LOWERED: begin
									if (hit) begin
										best_q <= item_err_q;
									end else begin
										gain_q[sel_q] <= gain_plus;
									end
									sel_q   <= sel_next;
									phase_q <= PH_INIT;
								end
								default: ;
							endcase
						end
					end
				end
				FE_WRITE: begin
					step_q[scale_idx_q] <= scaled;
					if (load_run_q) begin
						load_idx_q <= load_idx_next;
						if (load_idx_q == GAIN_D) begin
							load_run_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			buf_err_q  <= track_error;
			buf_tune_q <= tune_enable;
		end
		if (take) begin
			item_err_q  <= buf_err_q;
			item_diff_q <= diff_new;
			item_tune_q <= buf_tune_q;
		end
		case (state_q)
			FE_DECIDE: begin
				mul_a_q     <= step_q[sel_q];
				mul_c_q     <= (phase_q == PH_LOWERED && !hit) ? SCALE_DOWN : SCALE_UP;
				scale_idx_q <= sel_q;
			end
			FE_LOAD: begin
				mul_a_q     <= gain_reg_q[load_idx_q];
				mul_c_q     <= SCALE_TENTH;
				scale_idx_q <= load_idx_q;
			end
			FE_SCALE: prod_q <= mul_a_q * mul_c_q;
			default:  ;
		endcase
	end

	always_comb begin
		push_word.kp    = gain_q[GAIN_P];
		push_word.ki    = gain_q[GAIN_I];
		push_word.kd    = gain_q[GAIN_D];
		push_word.err   = item_err_q;
		push_word.diff  = item_diff_q;
		push_word.integ = INTEG_W'(sum_q);
		push_word.conv  = step_total <= TOTAL_W'(tol_q);
	end

endmodule

### rtl/core/pwt_queue.sv
// Short queue of classified words between the front end and the back end.
module pwt_queue import pwt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_req,
	output logic  q_full,
	input  work_t push_word,
	input  logic  q_pop,
	output logic  q_valid,
	output work_t q_head
);

	work_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               push_fire;

	assign q_full    = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign q_valid   = count_q != '0;
	assign q_head    = mem_q[rd_ptr_q];
	assign push_fire = push_req && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W + 1)'(push_fire) - (QPTR_W + 1)'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

### rtl/core/pwt_back.sv
// Back end: steering sum on one shared multiplier, saturation and output register.
module pwt_back import pwt_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  work_t                   q_head,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [ERR_W-1:0] steer_out,
	output logic                    tuning_converged
);

	localparam int MUL_W = GAIN_W + DIFF_W;
	localparam int ACC_W = GAIN_W + INTEG_W + 2;
	localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_W'(1);
	localparam logic signed [ACC_W-1:0] NEG_2_63 = -(ACC_ONE <<< 63);
	localparam logic signed [ACC_W-1:0] T_LOW    = -((ACC_ONE <<< 31) - ACC_ONE);
	localparam logic signed [ACC_W-1:0] T_HIGH   = ACC_ONE <<< 31;

	be_state_t state_q, state_d;
	mul_step_t cnt_q;
	work_t     cur_q;

	logic signed [GAIN_W-1:0] mul_a;
	logic signed [DIFF_W-1:0] mul_b;
	logic signed [MUL_W-1:0]  prod_s1;
	logic                     pvld_s1, phi_s1;
	logic signed [ACC_W-1:0]  acc_q, addend, shifted, negated;
	logic signed [ERR_W-1:0]  steer_d;
	logic                     out_load;

	logic                    out_valid_q;
	logic signed [ERR_W-1:0] steer_q;
	logic                    conv_q;

	always_comb begin
		case (cnt_q)
			MS_PROP: begin
				mul_a = cur_q.kp;
				mul_b = DIFF_W'(cur_q.err);
			end
			MS_DERIV: begin
				mul_a = cur_q.kd;
				mul_b = cur_q.diff;
			end
			MS_INTEG_LO: begin
				mul_a = cur_q.ki;
				mul_b = signed'({1'b0, cur_q.integ[31:0]});
			end
			default: begin
				mul_a = cur_q.ki;
				mul_b = DIFF_W'(signed'(cur_q.integ[INTEG_W-1:32]));
			end
		endcase
	end

	assign addend  = phi_s1 ? (ACC_W'(prod_s1) <<< 32) : ACC_W'(prod_s1);
	assign shifted = acc_q >>> FRAC_BITS;
	assign negated = -shifted;

	always_comb begin
		if (shifted == NEG_2_63) begin
			steer_d = 32'sh8000_0000;
		end else if (shifted < T_LOW) begin
			steer_d = 32'sh7FFF_FFFF;
		end else if (shifted > T_HIGH) begin
			steer_d = 32'sh8000_0000;
		end else begin
			steer_d = negated[ERR_W-1:0];
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BE_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BE_MUL;
				end
			end
			BE_MUL: begin
				if (cnt_q == MS_INTEG_HI) begin
					state_d = BE_ACC;
				end
			end
			BE_ACC: state_d = BE_SAT;
			BE_SAT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = BE_IDLE;
				end
			end
			default: state_d = BE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BE_IDLE;
			cnt_q       <= MS_PROP;
			pvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pvld_s1 <= state_q == BE_MUL;
			if (q_pop) begin
				cnt_q <= MS_PROP;
			end else if (state_q == BE_MUL) begin
				cnt_q <= mul_step_t'(cnt_q + 2'd1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
			acc_q <= '0;
		end else if (pvld_s1) begin
			acc_q <= acc_q + addend;
		end
		prod_s1 <= mul_a * mul_b;
		phi_s1  <= cnt_q == MS_INTEG_HI;
		if (out_load) begin
			steer_q <= steer_d;
			conv_q  <= cur_q.conv;
		end
	end

	assign out_valid        = out_valid_q;
	assign steer_out        = steer_q;
	assign tuning_converged = conv_q;

endmodule

### rtl/core/pid_with_twiddle_tuning_core.sv
// Top level of the PID steering controller with twiddle gain tuning.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  track_error, tune_enable
//   output   out        out_valid/out_stall  steer_out, tuning_converged
//   config   in         cfg_we               cfg_index, cfg_data
//
// The back end works on one word at a time: its one 32x33 multiplier forms four partial
// products in turn, then the sum is saturated. The front end also processes one word at a time.
// A word sits in the input buffer, the front end, two queue slots, the back end and the
// output register independently. Reset clears all gains and steps to zero and the
// tolerance to 655. A gain register write starts a reload pass; words wait in the input
// buffer meanwhile.
module pid_with_twiddle_tuning_core import pwt_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int SUM_BITS  = 40
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [ERR_W-1:0] track_error,
	input  logic                    tune_enable,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [ERR_W-1:0] steer_out,
	output logic                    tuning_converged,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [REG_W-1:0]        cfg_data
);

	localparam logic [2:0] MAX_INFLIGHT = 3'd6;

	logic  push_req, q_full, q_pop, q_valid;
	work_t push_word, q_head;
	logic  in_fire, out_fire;
	logic [2:0] inflight_q;

	pwt_front #(
		.SUM_BITS(SUM_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.track_error(track_error),
		.tune_enable(tune_enable),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_req   (push_req),
		.q_full     (q_full),
		.push_word  (push_word)
	);

	pwt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_req (push_req),
		.q_full   (q_full),
		.push_word(push_word),
		.q_pop    (q_pop),
		.q_valid  (q_valid),
		.q_head   (q_head)
	);

	pwt_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.steer_out       (steer_out),
		.tuning_converged(tuning_converged)
	);

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_fire) - 3'(out_fire);
		end
	end

	a_pop_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_no_invented_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> inflight_q != 3'd0)
		else $error("result word delivered without an outstanding input word");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= MAX_INFLIGHT)
		else $error("more words in flight than the storage can hold");

endmodule
